### design/adv_local_name_filter_core_assert.svh
// assertion macros shared by the local name filter rtl
`ifndef ADV_LOCAL_NAME_FILTER_CORE_ASSERT_SVH
`define ADV_LOCAL_NAME_FILTER_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define ALNF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define ALNF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/alnf_pkg.sv
// shared types and constants of the local name filter
`default_nettype none

package alnf_pkg;

    localparam int MAX_NAME_BYTES   = 32;
    localparam int MAX_REPORT_BYTES = 31;

    // target storage holds at most four 64-bit words
    localparam int NAME_CAP = (MAX_NAME_BYTES < 32) ? MAX_NAME_BYTES : 32;
    localparam int TAKEN_W  = $clog2(MAX_REPORT_BYTES + 1);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int NAME_LEN_W  = 6;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_NAME_LEN   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NAME_WORD0 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NAME_WORD1 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_NAME_WORD2 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_NAME_WORD3 = 3'd4;

    // advertising data types of interest
    localparam logic [7:0] TYPE_SHORT_NAME    = 8'h08;
    localparam logic [7:0] TYPE_COMPLETE_NAME = 8'h09;

    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_COMPLETE = 2'd1,
        KIND_SHORT    = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        PH_LENGTH = 3'b001,
        PH_TYPE   = 3'b010,
        PH_VALUE  = 3'b100
    } t_phase;

    // one result, match in bit 0
    typedef struct packed {
        logic  malformed;
        t_kind kind;
        logic  match;
    } t_result;

endpackage

`default_nettype wire

### design/alnf_target.sv
// target name registers and per-position byte lookup
`default_nettype none

module alnf_target (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wen,
    input  wire logic [alnf_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [alnf_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  wire logic [7:0]                        i_position,
    output logic [7:0]                             o_target_byte
);
    import alnf_pkg::*;

    logic [NAME_LEN_W-1:0] r_len;
    logic [63:0]           r_words [4];
    logic [7:0]            w_limit;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_words[0] <= '0;
            r_words[1] <= '0;
            r_words[2] <= '0;
            r_words[3] <= '0;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_index)
                REG_NAME_LEN:   r_len      <= i_cfg_wdata[NAME_LEN_W-1:0];
                REG_NAME_WORD0: r_words[0] <= i_cfg_wdata;
                REG_NAME_WORD1: r_words[1] <= i_cfg_wdata;
                REG_NAME_WORD2: r_words[2] <= i_cfg_wdata;
                REG_NAME_WORD3: r_words[3] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // effective length clipped to the storage
    always_comb begin
        if (8'(r_len) > 8'(NAME_CAP)) begin
            w_limit = 8'(NAME_CAP);
        end else begin
            w_limit = 8'(r_len);
        end
    end

    // bytes past the length read as zero
    always_comb begin
        if (i_position >= w_limit) begin
            o_target_byte = 8'h00;
        end else begin
            o_target_byte = r_words[i_position[4:3]][{i_position[2:0], 3'b000} +: 8];
        end
    end

endmodule

`default_nettype wire

### design/alnf_parser.sv
// length-type-value walker with running name compare
`default_nettype none
`include "adv_local_name_filter_core_assert.svh"

module alnf_parser (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_last,
    input  wire logic [7:0]       i_target_byte,
    output logic [7:0]            o_position,
    output alnf_pkg::t_result     o_result
);
    import alnf_pkg::*;

    t_phase             r_phase,     n_phase;
    logic [7:0]         r_left,      n_left;
    logic [7:0]         r_pos,       n_pos;
    t_kind              r_kind,      n_kind;
    logic               r_cfound,    n_cfound;
    logic               r_cequal,    n_cequal;
    logic               r_sfound,    n_sfound;
    logic               r_sequal,    n_sequal;
    logic               r_malformed, n_malformed;
    logic [TAKEN_W-1:0] r_taken,     n_taken;

    logic w_same;
    logic w_cfound_fin;
    logic w_sfound_fin;

    assign o_position = r_pos;
    assign w_same     = (i_byte == i_target_byte);

    // next parse state and the end-of-report result
    always_comb begin
        n_phase     = r_phase;
        n_left      = r_left;
        n_pos       = r_pos;
        n_kind      = r_kind;
        n_cfound    = r_cfound;
        n_cequal    = r_cequal;
        n_sfound    = r_sfound;
        n_sequal    = r_sequal;
        n_malformed = r_malformed;
        n_taken     = r_taken;
        w_cfound_fin = 1'b0;
        w_sfound_fin = 1'b0;
        o_result     = '{malformed: 1'b0, kind: KIND_NONE, match: 1'b0};

        if (i_step) begin
            if (r_taken < TAKEN_W'(MAX_REPORT_BYTES)) begin
                n_taken = TAKEN_W'(r_taken + 1'b1);
                unique case (r_phase)
                    PH_LENGTH: begin
                        if (i_byte == 8'h00) begin
                            n_malformed = 1'b1;
                        end else begin
                            n_left  = 8'(i_byte - 8'd1);
                            n_phase = PH_TYPE;
                        end
                    end
                    PH_TYPE: begin
                        n_kind = KIND_NONE;
                        n_pos  = 8'h00;
                        if (i_byte == TYPE_COMPLETE_NAME && !r_cfound) begin
                            n_kind   = KIND_COMPLETE;
                            n_cfound = 1'b1;
                            n_cequal = 1'b1;
                        end else if (i_byte == TYPE_SHORT_NAME && !r_sfound) begin
                            n_kind   = KIND_SHORT;
                            n_sfound = 1'b1;
                            n_sequal = 1'b1;
                        end
                        n_phase = (r_left == 8'h00) ? PH_LENGTH : PH_VALUE;
                    end
                    PH_VALUE: begin
                        if (r_kind == KIND_COMPLETE && !w_same) begin
                            n_cequal = 1'b0;
                        end
                        if (r_kind == KIND_SHORT && !w_same) begin
                            n_sequal = 1'b0;
                        end
                        n_pos  = 8'(r_pos + 8'd1);
                        n_left = 8'(r_left - 8'd1);
                        if (r_left == 8'd1) begin
                            n_phase = PH_LENGTH;
                        end
                    end
                    default: n_phase = PH_LENGTH;
                endcase
            end else begin
                // bytes beyond the report limit are dropped
                n_malformed = 1'b1;
            end

            if (i_last) begin
                // a field cut off by the end counts as not found
                w_cfound_fin = n_cfound && !(n_phase == PH_VALUE && n_kind == KIND_COMPLETE);
                w_sfound_fin = n_sfound && !(n_phase == PH_VALUE && n_kind == KIND_SHORT);
                o_result.malformed = n_malformed || (n_phase != PH_LENGTH);
                if (w_cfound_fin) begin
                    o_result.kind  = KIND_COMPLETE;
                    o_result.match = n_cequal;
                end else if (w_sfound_fin) begin
                    o_result.kind  = KIND_SHORT;
                    o_result.match = n_sequal;
                end

                // fresh state for the next report
                n_phase     = PH_LENGTH;
                n_left      = 8'h00;
                n_pos       = 8'h00;
                n_kind      = KIND_NONE;
                n_cfound    = 1'b0;
                n_cequal    = 1'b1;
                n_sfound    = 1'b0;
                n_sequal    = 1'b1;
                n_malformed = 1'b0;
                n_taken     = '0;
            end
        end
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LENGTH;
            r_left      <= 8'h00;
            r_pos       <= 8'h00;
            r_kind      <= KIND_NONE;
            r_cfound    <= 1'b0;
            r_cequal    <= 1'b1;
            r_sfound    <= 1'b0;
            r_sequal    <= 1'b1;
            r_malformed <= 1'b0;
            r_taken     <= '0;
        end else begin
            r_phase     <= n_phase;
            r_left      <= n_left;
            r_pos       <= n_pos;
            r_kind      <= n_kind;
            r_cfound    <= n_cfound;
            r_cequal    <= n_cequal;
            r_sfound    <= n_sfound;
            r_sequal    <= n_sequal;
            r_malformed <= n_malformed;
            r_taken     <= n_taken;
        end
    end

    // checks
    `ALNF_ASSERT_NEXT(a_clear_after_end, i_clk, i_rst_n, i_step && i_last,
        r_phase == PH_LENGTH && r_taken == '0 && !r_malformed && !r_cfound && !r_sfound,
        "parse state not cleared after end of report")
    `ALNF_ASSERT_IMPL(a_taken_bound, i_clk, i_rst_n, 1'b1,
        r_taken <= TAKEN_W'(MAX_REPORT_BYTES), "byte count beyond report limit")
    `ALNF_ASSERT_IMPL(a_value_left, i_clk, i_rst_n, r_phase == PH_VALUE,
        r_left != 8'h00, "value phase with no bytes left")

endmodule

`default_nettype wire

### design/adv_local_name_filter_core.sv
// top level of the advertising local name filter
`default_nettype none
`include "adv_local_name_filter_core_assert.svh"

// Takes one advertising report payload byte per request on the slave stream and
// returns one result per report, on the byte marked tlast. A byte can be taken
// every cycle: it lands in an input register, the parser consumes it from there
// with a single compare against the target byte at the running position, and the
// result of a report is registered on the master stream when its last byte is
// consumed. A stalled result only holds back the next report's last byte; other
// bytes keep flowing. Only the first complete name (type 0x09) and the first short
// name (type 0x08) are compared; a complete name decides the match when present.
// Zero-length and truncated fields and over-long reports set the malformed flag.
// Program the target name through the write port while no report is open.
module adv_local_name_filter_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write port
    input  wire logic                              i_cfg_wen,
    input  wire logic [alnf_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [alnf_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // report bytes
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [7:0]                        s_axis_tdata,  // [7:0] report_byte
    input  wire logic                              s_axis_tlast,  // report_end
    // results
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [7:0]                             m_axis_tdata,  // [0] name_match
    output logic [2:0]                             m_axis_tuser   // [1:0] name_kind, [2] malformed
);
    import alnf_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out_result;

    logic       w_advance;
    logic [7:0] w_position;
    logic [7:0] w_target_byte;
    t_result    w_result;

    // the staged byte moves on unless it ends a report and the result slot is full and not being read
    assign w_advance     = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // target name registers
    alnf_target u_target (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_position    (w_position),
        .o_target_byte (w_target_byte)
    );

    // field walker
    alnf_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_advance),
        .i_byte        (r_in_byte),
        .i_last        (r_in_last),
        .i_target_byte (w_target_byte),
        .o_position    (w_position),
        .o_result      (w_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_last) begin
            r_out_result <= w_result;
        end
    end

    // output packing
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0000000, r_out_result.match};
    assign m_axis_tuser  = {r_out_result.malformed, r_out_result.kind};

    // checks
    `ALNF_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, w_advance && r_in_last,
        r_out_valid, "report end consumed without a result")
    `ALNF_ASSERT_IMPL(a_nomatch_none, i_clk, i_rst_n,
        r_out_valid && r_out_result.kind == KIND_NONE,
        !r_out_result.match, "match reported with no name field")

endmodule

`default_nettype wire

### verif/testbench.sv
// testbench for the advertising local name filter: random reports checked against a local parser
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import alnf_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int RANDOM_PHASES   = 9;
    localparam int BYTES_PER_PHASE = 128;

    // first index past the register list, writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_FIRST = REG_NAME_WORD3 + 3'd1;

    // opening reports, bit 8 marks the last byte of a report
    localparam int OPENING_LEN = 26;
    localparam logic [8:0] OPENING_SEQ [OPENING_LEN] = '{
        // complete name padded past the target length, then a repeated complete name
        9'h004, 9'h009, 9'h041, 9'h042, 9'h000, 9'h002, 9'h009, 9'h158,
        // short name matches, complete name differs
        9'h002, 9'h008, 9'h041, 9'h003, 9'h009, 9'h041, 9'h158,
        // zero length byte ahead of a matching short name
        9'h000, 9'h003, 9'h008, 9'h041, 9'h142,
        // complete name cut off by the report end
        9'h005, 9'h009, 9'h141,
        // empty complete name
        9'h001, 9'h109,
        // lone length byte
        9'h1FF
    };

    typedef enum int {
        PACE_FULL,
        PACE_RANDOM,
        PACE_SPARSE
    } t_pace;

    // parser of the advertising payload and the queue of expected verdicts
    class name_match_tracker;
        logic [NAME_LEN_W-1:0] name_len;
        logic [63:0]           name_words [4];
        t_phase                phase;
        logic [7:0]            left;
        logic [7:0]            pos;
        t_kind                 field_kind;
        bit                    complete_found;
        bit                    complete_equal;
        bit                    short_found;
        bit                    short_equal;
        bit                    malformed;
        int                    taken;
        t_result               verdicts [$];
        int                    errors;

        function new();
            name_len = '0;
            foreach (name_words[i]) name_words[i] = '0;
            errors = 0;
            clear_report();
        endfunction

        function void clear_report();
            phase          = PH_LENGTH;
            left           = '0;
            pos            = '0;
            field_kind     = KIND_NONE;
            complete_found = 1'b0;
            complete_equal = 1'b1;
            short_found    = 1'b0;
            short_equal    = 1'b1;
            malformed      = 1'b0;
            taken          = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_NAME_LEN:   name_len = data[NAME_LEN_W-1:0];
                REG_NAME_WORD0: name_words[0] = data;
                REG_NAME_WORD1: name_words[1] = data;
                REG_NAME_WORD2: name_words[2] = data;
                REG_NAME_WORD3: name_words[3] = data;
                default: ;
            endcase
        endfunction

        // target reads as zero at and past its length
        function logic [7:0] target_at(int p);
            int lim;
            lim = (name_len > NAME_CAP) ? NAME_CAP : name_len;
            if (p >= lim)
                return 8'h00;
            return name_words[(p >> 3) & 3][(p & 7) * 8 +: 8];
        endfunction

        // one accepted payload byte, a verdict is queued on the last one
        function void note_byte(logic [7:0] b, logic last);
            t_result v;
            bit same;
            if (taken < MAX_REPORT_BYTES) begin
                taken++;
                case (phase)
                    PH_LENGTH: begin
                        if (b == 8'h00) begin
                            malformed = 1'b1;
                        end else begin
                            left  = b - 8'd1;
                            phase = PH_TYPE;
                        end
                    end
                    PH_TYPE: begin
                        field_kind = KIND_NONE;
                        pos        = '0;
                        if (b == TYPE_COMPLETE_NAME && !complete_found) begin
                            field_kind     = KIND_COMPLETE;
                            complete_found = 1'b1;
                            complete_equal = 1'b1;
                        end else if (b == TYPE_SHORT_NAME && !short_found) begin
                            field_kind  = KIND_SHORT;
                            short_found = 1'b1;
                            short_equal = 1'b1;
                        end
                        phase = (left == 8'd0) ? PH_LENGTH : PH_VALUE;
                    end
                    default: begin
                        same = (b == target_at(pos));
                        if (field_kind == KIND_COMPLETE && !same)
                            complete_equal = 1'b0;
                        if (field_kind == KIND_SHORT && !same)
                            short_equal = 1'b0;
                        pos  = pos + 8'd1;
                        left = left - 8'd1;
                        if (left == 8'd0)
                            phase = PH_LENGTH;
                    end
                endcase
            end else begin
                // past the byte limit nothing is parsed
                malformed = 1'b1;
            end

            if (!last)
                return;

            // a field still open at the end counts as not found
            if (phase == PH_TYPE) begin
                malformed = 1'b1;
            end else if (phase == PH_VALUE) begin
                malformed = 1'b1;
                if (field_kind == KIND_COMPLETE)
                    complete_found = 1'b0;
                if (field_kind == KIND_SHORT)
                    short_found = 1'b0;
            end

            v.kind  = KIND_NONE;
            v.match = 1'b0;
            if (complete_found) begin
                v.kind  = KIND_COMPLETE;
                v.match = complete_equal;
            end else if (short_found) begin
                v.kind  = KIND_SHORT;
                v.match = short_equal;
            end
            v.malformed = malformed;
            verdicts.push_back(v);
            clear_report();
        endfunction

        function void check_verdict(logic [7:0] data, logic [2:0] user);
            t_result want;
            if (verdicts.size() == 0) begin
                $error("result with no report pending: tdata %h tuser %h", data, user);
                errors++;
                return;
            end
            want = verdicts.pop_front();
            if (data[0] !== want.match) begin
                $error("name_match: expected %0d, got %0d", want.match, data[0]);
                errors++;
            end
            if (user[1:0] !== want.kind) begin
                $error("name_kind: expected %0d, got %0d", want.kind, user[1:0]);
                errors++;
            end
            if (user[2] !== want.malformed) begin
                $error("malformed: expected %0d, got %0d", want.malformed, user[2]);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_wen;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;   // [7:0] report_byte
    logic                   s_axis_tlast;   // report_end
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [7:0]             m_axis_tdata;   // [0] name_match
    logic [2:0]             m_axis_tuser;   // [1:0] name_kind, [2] malformed

    name_match_tracker tracker;
    logic [7:0]        report_q [$];
    t_pace             tx_pace;
    t_pace             rx_pace;
    int                cycle_count = 0;

    adv_local_name_filter_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // watch register writes, accepted bytes and accepted results
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_wen)
            tracker.write_reg(i_cfg_index, i_cfg_wdata);
        if (i_rst_n && s_axis_tvalid && s_axis_tready === 1'b1)
            tracker.note_byte(s_axis_tdata, s_axis_tlast);
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
            tracker.check_verdict(m_axis_tdata, m_axis_tuser);
    end

    function automatic int draw_wait(t_pace pace);
        case (pace)
            PACE_FULL:   return 0;
            PACE_RANDOM: return $urandom_range(0, 14);
            default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
        endcase
    endfunction

    // result side stalls at random between results
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = draw_wait(rx_pace);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
        end
    end

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_wen   <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    // all five registers, then a write past the list that must be dropped
    task automatic load_target(input logic [NAME_LEN_W-1:0] len,
                               input logic [63:0] w0, w1, w2, w3);
        cfg_write(REG_NAME_LEN, CFG_DATA_W'(len));
        cfg_write(REG_NAME_WORD0, w0);
        cfg_write(REG_NAME_WORD1, w1);
        cfg_write(REG_NAME_WORD2, w2);
        cfg_write(REG_NAME_WORD3, w3);
        cfg_write(REG_UNUSED_FIRST + 3'($urandom_range(0, 2)), {$urandom, $urandom});
        i_cfg_wen <= 1'b0;
        @(posedge i_clk);
    endtask

    // hold the request until the block takes it, noise on the bus while idle
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = draw_wait(tx_pace);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            s_axis_tlast  <= 1'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
    endtask

    task automatic send_report();
        for (int i = 0; i < report_q.size(); i++)
            send_byte(report_q[i], i == report_q.size() - 1);
    endtask

    // drain all results and let the pipeline empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // mostly well-formed reports with name fields near the target
    function automatic void build_report();
        int         shape;
        int         nfields;
        int         pick;
        int         vlen;
        int         eff;
        int         bad;
        int         room;
        int         goal;
        bit         is_name;
        logic [7:0] code;
        logic [7:0] b;

        report_q.delete();
        eff   = (tracker.name_len > NAME_CAP) ? NAME_CAP : tracker.name_len;
        shape = $urandom_range(0, 99);

        // pure noise
        if (shape < 6) begin
            repeat ($urandom_range(1, 40)) report_q.push_back(8'($urandom));
            return;
        end

        nfields = $urandom_range(1, 4);
        for (int f = 0; f < nfields; f++) begin
            // stray zero length byte
            if (shape >= 70 && shape < 80 && $urandom_range(0, 2) == 0)
                report_q.push_back(8'h00);
            pick = $urandom_range(0, 9);
            if (pick < 4)
                code = TYPE_COMPLETE_NAME;
            else if (pick < 7)
                code = TYPE_SHORT_NAME;
            else
                code = 8'($urandom);
            is_name = (code == TYPE_COMPLETE_NAME || code == TYPE_SHORT_NAME);
            if (is_name) begin
                case ($urandom_range(0, 3))
                    0, 1:    vlen = eff;
                    2:       vlen = $urandom_range(0, eff + 3);
                    default: vlen = $urandom_range(0, 8);
                endcase
            end else begin
                vlen = $urandom_range(0, 6);
            end
            room = MAX_REPORT_BYTES - report_q.size() - 2;
            if (shape < 70) begin
                if (room < 0)
                    break;
                if (vlen > room)
                    vlen = room;
            end
            bad = (is_name && vlen > 0 && $urandom_range(0, 3) == 0) ?
                  $urandom_range(0, vlen - 1) : -1;
            report_q.push_back(8'(vlen + 1));
            report_q.push_back(code);
            for (int i = 0; i < vlen; i++) begin
                b = is_name ? tracker.target_at(i) : 8'($urandom);
                if (i == bad)
                    b = b ^ 8'($urandom_range(1, 255));
                report_q.push_back(b);
            end
        end

        if (shape >= 80 && shape < 90 && report_q.size() > 1) begin
            // cut the last field short
            repeat ($urandom_range(1, (report_q.size() > 5) ? 4 : report_q.size() - 1))
                void'(report_q.pop_back());
        end else if (shape >= 90) begin
            // run past the byte limit
            goal = MAX_REPORT_BYTES + $urandom_range(1, 9);
            while (report_q.size() < goal)
                report_q.push_back(8'($urandom));
        end
    endfunction

    initial begin
        logic [NAME_LEN_W-1:0] len;
        logic [63:0]           words [4];
        int                    sent;

        tracker       = new();
        tx_pace       = PACE_SPARSE;
        rx_pace       = PACE_SPARSE;
        i_rst_n       <= 1'b0;
        i_cfg_wen     <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed reports against the two byte name "AB"
        load_target(6'd2, 64'hFFEE_DDCC_BBAA_4241, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom});
        for (int i = 0; i < OPENING_LEN; i++)
            send_byte(OPENING_SEQ[i][7:0], OPENING_SEQ[i][8]);

        // random phases over target settings and pacing
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            case (ph)
                0:       len = '0;
                1:       len = NAME_LEN_W'(NAME_CAP);
                2:       len = '1;
                default: len = NAME_LEN_W'($urandom_range(1, 12));
            endcase
            foreach (words[i]) begin
                if (ph == 3)
                    words[i] = '1;
                else if (ph == 4)
                    words[i] = '0;
                else
                    words[i] = {$urandom, $urandom};
            end
            load_target(len, words[0], words[1], words[2], words[3]);
            tx_pace = t_pace'(ph % 3);
            rx_pace = t_pace'((ph / 3) % 3);
            sent = 0;
            while (sent < BYTES_PER_PHASE) begin
                build_report();
                send_report();
                sent += report_q.size();
            end
        end
        settle();

        if (tracker.errors == 0 && tracker.verdicts.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
